// File: design/sqt_pkg.sv
package sqt_pkg;

  localparam int MaxPoints = 16;
  localparam int PtW = $clog2(MaxPoints);
  localparam int EntW = PtW + 2;
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int TotW = 7;

  localparam logic [1:0] MODE_FQUAD = 2'd0;
  localparam logic [1:0] MODE_FTRIA = 2'd1;
  localparam logic [1:0] MODE_CQUAD = 2'd2;
  localparam logic [1:0] MODE_CTRIA = 2'd3;

  localparam logic signed [31:0] ONE_Q = 32'sh1000_0000;
  localparam logic signed [31:0] NEG_ONE_Q = -32'sh1000_0000;

  typedef struct packed {
    logic       load;
    logic [PtW-1:0] pt;
    logic [1:0] nd;
    logic signed [31:0] sv;
    logic signed [31:0] dx;
    logic signed [31:0] de;
    logic signed [31:0] w;
    logic [1:0] mode;
    logic [1:0] corner;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } cmd_t;

  function automatic logic signed [31:0] sq_x(input logic [1:0] i);
    return (i == 2'd1 || i == 2'd2) ? ONE_Q : NEG_ONE_Q;
  endfunction

  function automatic logic signed [31:0] sq_y(input logic [1:0] i);
    return (i == 2'd2 || i == 2'd3) ? ONE_Q : NEG_ONE_Q;
  endfunction

  function automatic logic signed [31:0] tr_x(input logic [1:0] i);
    return (i == 2'd1) ? ONE_Q : 32'sd0;
  endfunction

  function automatic logic signed [31:0] tr_y(input logic [1:0] i);
    return (i == 2'd2) ? ONE_Q : 32'sd0;
  endfunction

  function automatic logic signed [63:0] rnd28(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = p + 64'sd134217728;
    return q >>> 28;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

// File: design/sqt_front.sv
module sqt_front
  import sqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [3:0]  in_point_index,
  input  logic [1:0]  in_node_index,
  input  logic signed [31:0] in_shape_value,
  input  logic signed [31:0] in_shape_dxi,
  input  logic signed [31:0] in_shape_deta,
  input  logic signed [31:0] in_base_weight,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_corner,
  input  logic signed [31:0] in_sing_xi,
  input  logic signed [31:0] in_sing_eta,
  output logic        q_valid,
  output cmd_t        q_data,
  input  logic        q_pop
);

  cmd_t       fifo_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       c;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = fifo_r[rp_r];

  always_comb begin
    c = '0;
    c.load = !in_command;
    c.pt = in_point_index[PtW-1:0];
    c.nd = in_node_index;
    c.sv = in_shape_value;
    c.dx = in_shape_dxi;
    c.de = in_shape_deta;
    c.w = in_base_weight;
    c.mode = in_mode;
    c.corner = in_corner;
    c.px = in_sing_xi;
    c.py = in_sing_eta;
    if (in_mode == MODE_CQUAD) begin
      c.px = sq_x(in_corner);
      c.py = sq_y(in_corner);
    end else if (in_mode == MODE_CTRIA) begin
      c.corner = (in_corner == 2'd3) ? 2'd0 : in_corner;
      c.px = tr_x(c.corner);
      c.py = tr_y(c.corner);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> in_stall)
    else $error("full queue not stalled");
`endif

endmodule

// File: design/sqt_back.sv
module sqt_back
  import sqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  rule_points,
  input  logic        q_valid,
  input  cmd_t        q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_xi_prime,
  output logic signed [31:0] out_eta_prime,
  output logic signed [31:0] out_weight_prime,
  output logic        out_last,
  output logic [6:0]  out_total_points
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DET  = 3'd3;
  localparam logic [2:0] S_WGT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic signed [31:0] shp_m [MaxPoints*4];
  logic signed [31:0] dxi_m [MaxPoints*4];
  logic signed [31:0] det_m [MaxPoints*4];
  logic signed [31:0] wgt_m [MaxPoints];

  logic [2:0]  st_r;
  cmd_t        cmd_r;
  logic [1:0]  cell_r;
  logic [PtW-1:0] pt_r;
  logic [1:0]  nd_r;
  logic [CntW-1:0] n_r;
  logic [6:0]  tot_r;
  logic signed [31:0] sv_r, dx_r, de_r, w_r;
  logic signed [63:0] sx_r, sy_r, xx_r, xe_r, ex_r, ee_r;
  logic signed [63:0] p0_r, p1_r;
  logic signed [31:0] det_r;
  logic signed [31:0] ox_r, oy_r, ow_r;
  logic        olast_r, ovalid_r;
  logic [6:0]  otot_r;

  logic [2:0]  st_nxt;
  logic [1:0]  ncells;
  logic [1:0]  va, vb;
  logic signed [31:0] xj, yj;
  logic [EntW-1:0] ra;
  logic        out_free;
  logic        last_cell, last_pt;

  assign out_free = !ovalid_r || !out_stall;
  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign last_cell = (cell_r == ncells - 2'd1);
  assign last_pt = ({1'b0, pt_r} == n_r - CntW'(1));

  always_comb begin
    unique case (cmd_r.mode)
      MODE_FQUAD: ncells = 2'd0;
      MODE_FTRIA: ncells = 2'd3;
      MODE_CQUAD: ncells = 2'd2;
      default:    ncells = 2'd1;
    endcase
  end

  always_comb begin
    va = cell_r;
    vb = cell_r + 2'd1;
    unique case (cmd_r.mode)
      MODE_FQUAD: ;
      MODE_FTRIA: vb = (cell_r == 2'd2) ? 2'd0 : cell_r + 2'd1;
      MODE_CQUAD: begin
        va = cmd_r.corner + cell_r + 2'd1;
        vb = cmd_r.corner + cell_r + 2'd2;
      end
      default: begin
        va = (cmd_r.corner == 2'd2) ? 2'd0 : cmd_r.corner + 2'd1;
        vb = (cmd_r.corner == 2'd0) ? 2'd2 : cmd_r.corner - 2'd1;
      end
    endcase
    xj = cmd_r.px;
    yj = cmd_r.py;
    if (nd_r == 2'd2 || nd_r == 2'd3) begin
      if (cmd_r.mode == MODE_FQUAD || cmd_r.mode == MODE_CQUAD) begin
        xj = sq_x(nd_r[0] ? vb : va);
        yj = sq_y(nd_r[0] ? vb : va);
      end else begin
        xj = tr_x(nd_r[0] ? vb : va);
        yj = tr_y(nd_r[0] ? vb : va);
      end
    end
  end

  assign ra = {pt_r, nd_r};

  always_ff @(posedge clk) begin
    if (q_pop && q_data.load && {1'b0, q_data.pt} < (PtW+1)'(MaxPoints)) begin
      shp_m[{q_data.pt, q_data.nd}] <= q_data.sv;
      dxi_m[{q_data.pt, q_data.nd}] <= q_data.dx;
      det_m[{q_data.pt, q_data.nd}] <= q_data.de;
      wgt_m[q_data.pt] <= q_data.w;
    end
    sv_r <= shp_m[ra];
    dx_r <= dxi_m[ra];
    de_r <= det_m[ra];
    w_r  <= wgt_m[pt_r];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid && !q_data.load) st_nxt = S_RD;
      S_RD:   st_nxt = S_MUL;
      S_MUL:  st_nxt = (nd_r == 2'd3) ? S_DET : S_RD;
      S_DET:  st_nxt = S_WGT;
      S_WGT:  st_nxt = S_OUT;
      S_OUT:  if (out_free) st_nxt = (last_pt && last_cell) ? S_IDLE : S_RD;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_free) ovalid_r <= (st_r == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        cmd_r <= q_data;
        cell_r <= 2'd0;
        pt_r <= '0;
        nd_r <= 2'd0;
        tot_r <= 7'd1;
        if (rule_points == 5'd0) n_r <= CntW'(1);
        else if (rule_points > 5'(MaxPoints)) n_r <= CntW'(MaxPoints);
        else n_r <= CntW'(rule_points);
        sx_r <= '0; sy_r <= '0; xx_r <= '0; xe_r <= '0; ex_r <= '0; ee_r <= '0;
      end
      S_MUL: begin
        sx_r <= sx_r + rnd28(64'(xj) * 64'(sv_r));
        sy_r <= sy_r + rnd28(64'(yj) * 64'(sv_r));
        xx_r <= xx_r + rnd28(64'(xj) * 64'(dx_r));
        xe_r <= xe_r + rnd28(64'(xj) * 64'(de_r));
        ex_r <= ex_r + rnd28(64'(yj) * 64'(dx_r));
        ee_r <= ee_r + rnd28(64'(yj) * 64'(de_r));
        nd_r <= nd_r + 2'd1;
      end
      S_DET: begin
        p0_r <= rnd28(64'(sat32(xx_r)) * 64'(sat32(ee_r)));
        p1_r <= rnd28(64'(sat32(xe_r)) * 64'(sat32(ex_r)));
      end
      S_WGT: det_r <= sat32(p0_r - p1_r);
      S_OUT: begin
        if (out_free) begin
          ox_r <= sat32(sx_r);
          oy_r <= sat32(sy_r);
          ow_r <= sat32(rnd28(64'(w_r) * 64'(det_r)));
          olast_r <= last_pt && last_cell;
          otot_r <= (last_pt && last_cell) ? tot_r : 7'd0;
          tot_r <= tot_r + 7'd1;
          sx_r <= '0; sy_r <= '0; xx_r <= '0; xe_r <= '0; ex_r <= '0; ee_r <= '0;
          if (last_pt) begin
            pt_r <= '0;
            cell_r <= cell_r + 2'd1;
          end else begin
            pt_r <= pt_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ovalid_r;
  assign out_xi_prime = ox_r;
  assign out_eta_prime = oy_r;
  assign out_weight_prime = ow_r;
  assign out_last = olast_r;
  assign out_total_points = otot_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result transaction dropped");
  a_tot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_total_points != 7'd0))
    else $error("last result without count");
  a_idle_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == S_IDLE))
    else $error("pop while busy");
`endif

endmodule

// File: design/singular_quadrature_transform_core.sv
// Channel | Handshake         | Contents
// in      | in_valid/in_stall | load or compute command
// out     | out_valid/out_stall | mapped point, weight, last, count
// cfg     | cfg_valid/cfg_ready | rule_points
// A load waits in the queue and is written to the tables when the idle back end pops it.
// Each result steps through four table reads with six products each, two
// determinant products, their difference, and the weight product into the
// output register. A compute leaves the queue in idle, before its first read.
// Reset is synchronous; the tables are not cleared.
// Output stall holds the back end; a two-entry queue holds commands while it is busy.
module singular_quadrature_transform_core
  import sqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [3:0]  in_point_index,
  input  logic [1:0]  in_node_index,
  input  logic signed [31:0] in_shape_value,
  input  logic signed [31:0] in_shape_dxi,
  input  logic signed [31:0] in_shape_deta,
  input  logic signed [31:0] in_base_weight,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_corner,
  input  logic signed [31:0] in_sing_xi,
  input  logic signed [31:0] in_sing_eta,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_xi_prime,
  output logic signed [31:0] out_eta_prime,
  output logic signed [31:0] out_weight_prime,
  output logic        out_last,
  output logic [6:0]  out_total_points,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_rule_points
);

  logic [4:0] rp_r;
  logic       q_valid, q_pop;
  cmd_t       q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) rp_r <= 5'd8;
    else if (cfg_valid) rp_r <= cfg_rule_points;
  end

  sqt_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_point_index,
    .in_node_index, .in_shape_value, .in_shape_dxi, .in_shape_deta,
    .in_base_weight, .in_mode, .in_corner, .in_sing_xi, .in_sing_eta,
    .q_valid, .q_data, .q_pop
  );

  sqt_back u_back (
    .clk, .rst_n, .rule_points(rp_r), .q_valid, .q_data, .q_pop,
    .out_valid, .out_stall, .out_xi_prime, .out_eta_prime,
    .out_weight_prime, .out_last, .out_total_points
  );

endmodule
